[rtl/avo_ta_pkg.sv]
// avo_ta_pkg: shared types and constants of the AVO trend attribute block.
// Depends on nothing; the top level, register file, datapath and the sim files use it.
`default_nettype none

package avo_ta_pkg;

  typedef enum logic [1:0] {
    MODE_FLUID = 2'd0,
    MODE_DIST  = 2'd1,
    MODE_SDIST = 2'd2,
    MODE_CLASS = 2'd3
  } mode_t;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_TREND = 3'd1,
    REG_SIN   = 3'd2,
    REG_COS   = 3'd3,
    REG_TAN   = 3'd4
  } reg_idx_t;

  // sign classes of an intercept/gradient pair
  typedef enum logic [1:0] {
    CLS_SAME = 2'd0,
    CLS_GPOS = 2'd1,
    CLS_GNEG = 2'd2
  } cls_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] trend_intercept;
    logic signed [17:0] sin_angle;
    logic signed [17:0] cos_angle;
    logic signed [31:0] tan_angle;
  } cfg_t;

  localparam logic signed [17:0] COS_RESET = 18'sd65536;
  localparam logic signed [31:0] HALF_Q16  = 32'sd32768;
  localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;

  // class codes in Q16.16
  localparam logic signed [31:0] CODE_P1 = 32'sd65536;
  localparam logic signed [31:0] CODE_M1 = -32'sd65536;
  localparam logic signed [31:0] CODE_P3 = 32'sd196608;
  localparam logic signed [31:0] CODE_M3 = -32'sd196608;
  localparam logic signed [31:0] CODE_P4 = 32'sd262144;
  localparam logic signed [31:0] CODE_M4 = -32'sd262144;

endpackage

`default_nettype wire

[rtl/avo_ta_in_if.sv]
// avo_ta_in_if: sample channel, valid/ready with the intercept/gradient pair.
// Stands alone; used by the datapath and the top level.
`default_nettype none

interface avo_ta_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] intercept_sample;
  logic signed [31:0] gradient_sample;
  logic               intercept_null;
  logic               gradient_null;

  modport source (
    output valid, intercept_sample, gradient_sample, intercept_null, gradient_null,
    input  ready
  );
  modport sink (
    input  valid, intercept_sample, gradient_sample, intercept_null, gradient_null,
    output ready
  );
endinterface

`default_nettype wire

[rtl/avo_ta_out_if.sv]
// avo_ta_out_if: result channel, valid/ready with the attribute value and flags.
// Stands alone; used by the datapath and the top level.
`default_nettype none

interface avo_ta_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] attribute_value;
  logic               value_written;
  logic               saturated;

  modport source (
    output valid, attribute_value, value_written, saturated,
    input  ready
  );
  modport sink (
    input  valid, attribute_value, value_written, saturated,
    output ready
  );
endinterface

`default_nettype wire

[rtl/avo_trend_attribute_top.sv]
// avo_trend_attribute_top: AVO attribute against a background trend line.
// Depends on avo_ta_pkg, avo_ta_in_if, avo_ta_out_if, avo_ta_cfg, avo_ta_pipe.
//
// Use:
//   Program mode, trend intercept G0, sin, cos and tan of the trend angle over
//   the APB port (register i at byte address 4*i, pready always high), then
//   stream intercept/gradient pairs into the samples channel. Each accepted
//   beat yields exactly one beat on the results channel, in order.
//   An accepted sample beat reaches the results channel through five register
//   stages (operand difference, multipliers, sum and trend side, rounding,
//   saturation and class select). Throughput: one beat per cycle while
//   results.ready is high; each stage takes a new beat every cycle unless stalled.
//   Stall: when results.ready is low the last stage holds its beat; earlier
//   stages keep advancing into empty slots, so samples.ready falls only once
//   every stage holds a beat. Nothing is dropped or repeated.
//   Reset (rst, synchronous, active high): empties the pipeline and returns
//   the registers to mode 0, G0 0, sin 0, cos 1.0, tan 0.
//   Write configuration only while the pipeline is empty.
`default_nettype none

module avo_trend_attribute_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // streams
  avo_ta_in_if.sink        samples,
  avo_ta_out_if.source     results
);

  avo_ta_pkg::cfg_t cfg;

  // register file: decode APB beats, hold the trend line coefficients
  avo_ta_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // datapath: one sample beat in, one result beat out, five stages deep
  avo_ta_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .samples (samples),
    .results (results)
  );

endmodule

`default_nettype wire

[rtl/avo_ta_cfg.sv]
// avo_ta_cfg: APB register file holding mode and trend line coefficients.
// Depends on avo_ta_pkg.
`default_nettype none

module avo_ta_cfg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output avo_ta_pkg::cfg_t        cfg
);

  avo_ta_pkg::reg_idx_t idx;
  logic                 wr;

  assign pready = 1'b1;
  assign idx    = avo_ta_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= avo_ta_pkg::MODE_FLUID;
      cfg.trend_intercept <= '0;
      cfg.sin_angle       <= '0;
      cfg.cos_angle       <= avo_ta_pkg::COS_RESET;
      cfg.tan_angle       <= '0;
    end else if (wr) begin
      unique case (idx)
        avo_ta_pkg::REG_MODE:  cfg.mode            <= avo_ta_pkg::mode_t'(pwdata[1:0]);
        avo_ta_pkg::REG_TREND: cfg.trend_intercept <= pwdata;
        avo_ta_pkg::REG_SIN:   cfg.sin_angle       <= pwdata[17:0];
        avo_ta_pkg::REG_COS:   cfg.cos_angle       <= pwdata[17:0];
        avo_ta_pkg::REG_TAN:   cfg.tan_angle       <= pwdata;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      avo_ta_pkg::REG_MODE:  prdata = {30'd0, cfg.mode};
      avo_ta_pkg::REG_TREND: prdata = cfg.trend_intercept;
      avo_ta_pkg::REG_SIN:   prdata = 32'(cfg.sin_angle);
      avo_ta_pkg::REG_COS:   prdata = 32'(cfg.cos_angle);
      avo_ta_pkg::REG_TAN:   prdata = cfg.tan_angle;
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/avo_ta_pipe.sv]
// avo_ta_pipe: five-stage datapath (difference, multiply, sum/trend side,
// round, saturate/select) with per-stage valid and bubble-collapsing stall.
// Depends on avo_ta_pkg, avo_ta_in_if and avo_ta_out_if.
`default_nettype none

module avo_ta_pipe (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire avo_ta_pkg::cfg_t cfg,
  avo_ta_in_if.sink        samples,
  avo_ta_out_if.source     results
);

  localparam int NSTG = 5;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || results.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign samples.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= samples.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: register pair, form G - G0 and the sign class
  logic signed [31:0] s1_i;
  logic signed [32:0] s1_d;
  logic               s1_null;
  avo_ta_pkg::cls_t   s1_cls;
  avo_ta_pkg::cls_t   cls_next;

  always_comb begin
    if (samples.intercept_sample == '0 || samples.gradient_sample == '0 ||
        samples.intercept_sample[31] == samples.gradient_sample[31]) begin
      cls_next = avo_ta_pkg::CLS_SAME;
    end else if (!samples.gradient_sample[31]) begin
      cls_next = avo_ta_pkg::CLS_GPOS;
    end else begin
      cls_next = avo_ta_pkg::CLS_GNEG;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_i    <= samples.intercept_sample;
      s1_d    <= 33'(samples.gradient_sample) - 33'(cfg.trend_intercept);
      s1_null <= samples.intercept_null || samples.gradient_null;
      s1_cls  <= cls_next;
    end
  end

  // stage 2: products
  logic signed [17:0] op_a;
  logic signed [17:0] op_b;
  logic signed [49:0] s2_m1;
  logic signed [50:0] s2_m2;
  logic signed [63:0] s2_t;
  logic signed [32:0] s2_d;
  logic               s2_null;
  avo_ta_pkg::cls_t   s2_cls;

  assign op_a = (cfg.mode == avo_ta_pkg::MODE_FLUID) ? cfg.sin_angle : cfg.cos_angle;
  assign op_b = (cfg.mode == avo_ta_pkg::MODE_FLUID) ? cfg.cos_angle : cfg.sin_angle;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_m1   <= 50'(s1_i) * 50'(op_a);
      s2_m2   <= 51'(s1_d) * 51'(op_b);
      s2_t    <= 64'(s1_i) * 64'(cfg.tan_angle);
      s2_d    <= s1_d;
      s2_null <= s1_null;
      s2_cls  <= s1_cls;
    end
  end

  // stage 3: combine products, place the sample against the trend line
  logic signed [65:0] trend;
  logic signed [51:0] s3_s;
  logic               s3_above;
  logic               s3_below;
  logic               s3_null;
  avo_ta_pkg::cls_t   s3_cls;

  assign trend = (66'(s2_d) <<< 16) + 66'(s2_t);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (cfg.mode == avo_ta_pkg::MODE_FLUID) begin
        s3_s <= 52'(s2_m1) + 52'(s2_m2);
      end else begin
        s3_s <= 52'(s2_m1) - 52'(s2_m2);
      end
      s3_below <= trend[65];
      s3_above <= !trend[65] && (trend != '0);
      s3_null  <= s2_null;
      s3_cls   <= s2_cls;
    end
  end

  // stage 4: flip below the trend in signed-distance mode, add half an LSB
  logic signed [52:0] s_sel;
  logic signed [53:0] s4_r;
  logic               s4_above;
  logic               s4_null;
  avo_ta_pkg::cls_t   s4_cls;

  assign s_sel = (cfg.mode == avo_ta_pkg::MODE_SDIST && s3_below) ?
                 -53'(s3_s) : 53'(s3_s);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_r     <= 54'(s_sel) + 54'(avo_ta_pkg::HALF_Q16);
      s4_above <= s3_above;
      s4_null  <= s3_null;
      s4_cls   <= s3_cls;
    end
  end

  // stage 5: floor to Q16.16, saturate, select the class code
  logic signed [37:0] q;
  logic signed [31:0] value_next;
  logic               sat_next;
  logic signed [31:0] code;
  logic signed [31:0] out_value;
  logic               out_written;
  logic               out_sat;

  assign q = 38'(s4_r >>> 16);

  always_comb begin
    case (s4_cls)
      avo_ta_pkg::CLS_SAME: code = s4_above ? avo_ta_pkg::CODE_P3 : avo_ta_pkg::CODE_M3;
      avo_ta_pkg::CLS_GPOS: code = s4_above ? avo_ta_pkg::CODE_P1 : avo_ta_pkg::CODE_M4;
      default:              code = s4_above ? avo_ta_pkg::CODE_P4 : avo_ta_pkg::CODE_M1;
    endcase

    if (s4_null) begin
      value_next = '0;
      sat_next   = 1'b0;
    end else if (cfg.mode == avo_ta_pkg::MODE_CLASS) begin
      value_next = code;
      sat_next   = 1'b0;
    end else if (q > 38'(avo_ta_pkg::Q_MAX)) begin
      value_next = avo_ta_pkg::Q_MAX;
      sat_next   = 1'b1;
    end else if (q < 38'(avo_ta_pkg::Q_MIN)) begin
      value_next = avo_ta_pkg::Q_MIN;
      sat_next   = 1'b1;
    end else begin
      value_next = q[31:0];
      sat_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      out_value   <= value_next;
      out_written <= !s4_null;
      out_sat     <= sat_next;
    end
  end

  assign results.valid           = vld[NSTG-1];
  assign results.attribute_value = out_value;
  assign results.value_written   = out_written;
  assign results.saturated       = out_sat;

  // a skipped sample carries a zero value and no clip flag
  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    (vld[NSTG-1] && !out_written) |-> (out_value == '0 && !out_sat))
    else $error("skipped sample with non-zero payload");

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[NSTG-1] && !results.ready) |=> (vld[NSTG-1] && $stable(out_value) &&
                                         $stable(out_sat)))
    else $error("result lost under stall");

  // a full first stage that cannot move holds its pair
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && !en[0]) |=> (vld[0] && $stable(s1_i) && $stable(s1_d)))
    else $error("first stage overwritten under stall");

  // the clip flag only appears on written values
  a_sat_written: assert property (@(posedge clk) disable iff (rst)
    (vld[NSTG-1] && out_sat) |-> out_written)
    else $error("saturated flag on skipped sample");

endmodule

`default_nettype wire

[sim/avo_ta_checker.sv]
// avo_ta_checker: watches the register port and both streams of the AVO trend
// attribute block, predicts each result beat and compares it field by field.
// Depends on avo_ta_pkg, avo_ta_in_if and avo_ta_out_if.
`timescale 1ns / 1ps

module avo_ta_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  avo_ta_in_if             samples,
  avo_ta_out_if            results,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               written;
    logic               sat;
  } attr_beat_t;

  // shadow of the block's registers, kept at full precision
  avo_ta_pkg::mode_t cfg_mode = avo_ta_pkg::MODE_FLUID;
  longint cfg_g0   = 0;
  longint cfg_sin  = 0;
  longint cfg_cos  = avo_ta_pkg::COS_RESET;
  longint cfg_tan  = 0;

  attr_beat_t attribute_due[$];
  int         mismatch_count = 0;

  function automatic attr_beat_t avo_attribute_of(input longint i, input longint g,
                                                  input logic inull, input logic gnull);
    attr_beat_t r;
    longint     acc;
    longint     q;
    longint     side;
    logic       up;
    r = '0;
    if (inull || gnull) return r;
    r.written = 1'b1;
    // sign of G - (G0 - I*tan), exact at scale 2^32
    side = g * 65536 + i * cfg_tan - cfg_g0 * 65536;
    up   = side > 0;
    if (cfg_mode == avo_ta_pkg::MODE_CLASS) begin
      if (i == 0 || g == 0 || ((i < 0) == (g < 0)))
        r.value = up ? avo_ta_pkg::CODE_P3 : avo_ta_pkg::CODE_M3;
      else if (g > 0)
        r.value = up ? avo_ta_pkg::CODE_P1 : avo_ta_pkg::CODE_M4;
      else
        r.value = up ? avo_ta_pkg::CODE_P4 : avo_ta_pkg::CODE_M1;
      return r;
    end
    if (cfg_mode == avo_ta_pkg::MODE_FLUID) begin
      acc = i * cfg_sin + g * cfg_cos - cfg_g0 * cfg_cos;
    end else begin
      acc = i * cfg_cos - (g - cfg_g0) * cfg_sin;
      if (cfg_mode == avo_ta_pkg::MODE_SDIST && side < 0) acc = -acc;
    end
    // round half up to Q16.16, then clip
    q = (acc + 32768) >>> 16;
    if (q > 64'sd2147483647) begin
      q = 64'sd2147483647;
      r.sat = 1'b1;
    end else if (q < -64'sd2147483648) begin
      q = -64'sd2147483648;
      r.sat = 1'b1;
    end
    r.value = q[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    attr_beat_t want;
    if (rst) begin
      cfg_mode = avo_ta_pkg::MODE_FLUID;
      cfg_g0   = 0;
      cfg_sin  = 0;
      cfg_cos  = avo_ta_pkg::COS_RESET;
      cfg_tan  = 0;
      attribute_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (avo_ta_pkg::reg_idx_t'(paddr[4:2]))
          avo_ta_pkg::REG_MODE:  cfg_mode = avo_ta_pkg::mode_t'(pwdata[1:0]);
          avo_ta_pkg::REG_TREND: cfg_g0   = longint'($signed(pwdata));
          avo_ta_pkg::REG_SIN:   cfg_sin  = longint'($signed(pwdata[17:0]));
          avo_ta_pkg::REG_COS:   cfg_cos  = longint'($signed(pwdata[17:0]));
          avo_ta_pkg::REG_TAN:   cfg_tan  = longint'($signed(pwdata));
          default: ;
        endcase
      end
      if (samples.valid && samples.ready)
        attribute_due.push_back(avo_attribute_of(longint'(samples.intercept_sample),
                                                 longint'(samples.gradient_sample),
                                                 samples.intercept_null,
                                                 samples.gradient_null));
      if (results.valid && results.ready) begin
        if (attribute_due.size() == 0) begin
          $display("%0t checker: result beat with nothing due, value %h", $time,
                   results.attribute_value);
          mismatch_count++;
        end else begin
          want = attribute_due.pop_front();
          if (results.attribute_value !== want.value) begin
            $display("%0t checker: attribute_value expected %h got %h", $time,
                     want.value, results.attribute_value);
            mismatch_count++;
          end
          if (results.value_written !== want.written) begin
            $display("%0t checker: value_written expected %b got %b", $time,
                     want.written, results.value_written);
            mismatch_count++;
          end
          if (results.saturated !== want.sat) begin
            $display("%0t checker: saturated expected %b got %b", $time,
                     want.sat, results.saturated);
            mismatch_count++;
          end
        end
      end
    end
    errors  <= mismatch_count;
    pending <= attribute_due.size();
  end

endmodule

[sim/avo_trend_attribute_top_tb.sv]
// avo_trend_attribute_top_tb: drives registers and sample beats into the AVO
// trend attribute block with random gaps and stalls; avo_ta_checker judges.
// Depends on avo_ta_pkg, both stream interfaces, the block and avo_ta_checker.
`timescale 1ns / 1ps

module avo_trend_attribute_top_tb;

  // register slot past the last one; writes there must change nothing
  localparam logic [2:0] REG_SPARE = 3'd5;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          beats_due;

  avo_ta_in_if  samples_if ();
  avo_ta_out_if results_if ();

  avo_trend_attribute_top u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .samples (samples_if),
    .results (results_if)
  );

  avo_ta_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .samples (samples_if),
    .results (results_if),
    .errors  (fail_count),
    .pending (beats_due)
  );

  // what was last programmed; used only to aim samples near the trend line
  avo_ta_pkg::mode_t cur_mode = avo_ta_pkg::MODE_FLUID;
  longint cur_g0   = 0;
  longint cur_tan  = 0;
  int     burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: sized well beyond the slowest legal run (every beat waiting out
  // a full receiver stall and a long sender gap).
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: alternate spans of always-ready, coin-toss ready and dead stall.
  initial begin
    int span;
    int style;
    results_if.ready <= 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(1, 40);
      repeat (span) begin
        @(posedge clk);
        case (style)
          0, 1:    results_if.ready <= 1'b1;
          2:       results_if.ready <= 1'($urandom_range(0, 1));
          default: results_if.ready <= 1'b0;
        endcase
      end
    end
  end

  // Random Q16.16 word, weighted towards the extremes, zero and small values.
  function automatic longint rand_q16();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 9))
      0:       return longint'(avo_ta_pkg::Q_MIN);
      1:       return longint'(avo_ta_pkg::Q_MAX);
      2:       return 0;
      3, 4:    return longint'($urandom_range(0, 262143)) - 131072;
      default: return longint'($signed(w));
    endcase
  endfunction

  // Sine/cosine register pattern: unit extremes, in-range values, or any
  // 18-bit pattern (out-of-range angles are taken as given).
  function automatic longint rand_angle();
    logic [17:0] w;
    w = 18'($urandom());
    case ($urandom_range(0, 4))
      0:       return ($urandom_range(0, 1) != 0) ? 65536 : -65536;
      1, 2:    return longint'($urandom_range(0, 131072)) - 65536;
      3:       return longint'($signed(w));
      default: return 0;
    endcase
  endfunction

  // One register write: setup cycle, access cycle, then a return to idle so the
  // next write never lowers and raises psel in the same step.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Program every register; junk goes into the unused upper bits of the
  // narrow ones so that every pwdata bit toggles.
  task automatic program_cfg(input avo_ta_pkg::mode_t m, input longint g0,
                             input longint s, input longint c, input longint t);
    logic [31:0] w;
    w = $urandom();
    w[1:0] = m;
    write_reg(avo_ta_pkg::REG_MODE, w);
    write_reg(avo_ta_pkg::REG_TREND, g0[31:0]);
    w = $urandom();
    w[17:0] = s[17:0];
    write_reg(avo_ta_pkg::REG_SIN, w);
    w = $urandom();
    w[17:0] = c[17:0];
    write_reg(avo_ta_pkg::REG_COS, w);
    write_reg(avo_ta_pkg::REG_TAN, t[31:0]);
    cur_mode = m;
    cur_g0   = longint'($signed(g0[31:0]));
    cur_tan  = longint'($signed(t[31:0]));
  endtask

  // Offer one sample beat and hold it until the block takes it. Valid stays
  // high on return so a burst can follow straight on.
  task automatic send_pair(input longint i, input longint g, input logic inull,
                           input logic gnull);
    samples_if.valid            <= 1'b1;
    samples_if.intercept_sample <= i[31:0];
    samples_if.gradient_sample  <= g[31:0];
    samples_if.intercept_null   <= inull;
    samples_if.gradient_null    <= gnull;
    do @(posedge clk); while (!samples_if.ready);
  endtask

  // Drop valid for a number of cycles, with noise on the payload.
  task automatic rest(input int cycles);
    repeat (cycles) begin
      samples_if.valid            <= 1'b0;
      samples_if.intercept_sample <= $urandom();
      samples_if.gradient_sample  <= $urandom();
      samples_if.intercept_null   <= 1'($urandom_range(0, 1));
      samples_if.gradient_null    <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
  endtask

  // Wait until every beat has come back, then let the pipeline settle.
  task automatic drain();
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random beats in bursts. In signed-distance and class modes half of them
  // sit within a couple of LSBs of the trend line so both sides get hit.
  task automatic run_phase(input int count);
    longint i;
    longint g;
    int     gap;
    for (int n = 0; n < count; n++) begin
      i = rand_q16();
      g = rand_q16();
      if (cur_mode >= avo_ta_pkg::MODE_SDIST && $urandom_range(0, 1) != 0) begin
        if ($urandom_range(0, 1) != 0) i = longint'($urandom_range(0, 131072)) - 65536;
        g = cur_g0 - ((i * cur_tan) >>> 16) + longint'($urandom_range(0, 4)) - 2;
        if (g > longint'(avo_ta_pkg::Q_MAX)) g = longint'(avo_ta_pkg::Q_MAX);
        if (g < longint'(avo_ta_pkg::Q_MIN)) g = longint'(avo_ta_pkg::Q_MIN);
      end
      send_pair(i, g, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 23);
        case ($urandom_range(0, 7))
          0, 1:    gap = 0;
          2, 3, 4: gap = $urandom_range(1, 4);
          5, 6:    gap = $urandom_range(5, 12);
          default: gap = $urandom_range(20, 30);
        endcase
        rest(gap);
      end
    end
  endtask

  initial begin
    int phase;
    // hold everything at known values through reset
    rst                         <= 1'b1;
    psel                        <= 1'b0;
    penable                     <= 1'b0;
    pwrite                      <= 1'b0;
    paddr                       <= '0;
    pwdata                      <= '0;
    samples_if.valid            <= 1'b0;
    samples_if.intercept_sample <= '0;
    samples_if.gradient_sample  <= '0;
    samples_if.intercept_null   <= 1'b0;
    samples_if.gradient_null    <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // a write past the last register must leave the reset values alone
    write_reg(REG_SPARE, $urandom());

    // reset values: fluid factor with cos 1.0 passes G straight through
    send_pair(0, 0, 1'b0, 1'b0);
    send_pair(longint'(avo_ta_pkg::Q_MAX), longint'(avo_ta_pkg::Q_MAX), 1'b0, 1'b0);
    send_pair(longint'(avo_ta_pkg::Q_MIN), longint'(avo_ta_pkg::Q_MIN), 1'b0, 1'b0);
    // null intercept, null gradient, both null
    send_pair(12345, -777, 1'b1, 1'b0);
    send_pair(-5, 99999, 1'b0, 1'b1);
    send_pair(longint'(avo_ta_pkg::Q_MAX), longint'(avo_ta_pkg::Q_MIN), 1'b1, 1'b1);
    drain();

    // unit sine and cosine: the sum overflows in both directions
    program_cfg(avo_ta_pkg::MODE_FLUID, 0, 65536, 65536, 0);
    send_pair(longint'(avo_ta_pkg::Q_MAX), longint'(avo_ta_pkg::Q_MAX), 1'b0, 1'b0);
    send_pair(longint'(avo_ta_pkg::Q_MIN), longint'(avo_ta_pkg::Q_MIN), 1'b0, 1'b0);
    drain();

    // cos of one LSB: exact half-way cases, which round up
    program_cfg(avo_ta_pkg::MODE_DIST, 0, 0, 1, 0);
    send_pair(32768, 0, 1'b0, 1'b0);
    send_pair(-32768, 0, 1'b0, 1'b0);
    send_pair(-32769, 0, 1'b0, 1'b0);
    drain();

    // trend G = 1.0 - I: on the line, below it, above it
    program_cfg(avo_ta_pkg::MODE_SDIST, 65536, -65536, 65536, 65536);
    send_pair(65536, 0, 1'b0, 1'b0);
    send_pair(0, 0, 1'b0, 1'b0);
    send_pair(0, 131072, 1'b0, 1'b0);
    drain();

    // class codes against a flat trend at zero
    program_cfg(avo_ta_pkg::MODE_CLASS, 0, -65536, 65536, 0);
    send_pair(0, 0, 1'b0, 1'b0);
    send_pair(1, 1, 1'b0, 1'b0);
    send_pair(-1, -1, 1'b0, 1'b0);
    send_pair(-1, 1, 1'b0, 1'b0);
    send_pair(1, -1, 1'b0, 1'b0);
    drain();
    // positive gradient below a raised trend
    program_cfg(avo_ta_pkg::MODE_CLASS, 65536, 0, 65536, 0);
    send_pair(-1, 5, 1'b0, 1'b0);
    drain();
    // negative gradient above a lowered trend
    program_cfg(avo_ta_pkg::MODE_CLASS, -65536, 0, 65536, 0);
    send_pair(5, -1, 1'b0, 1'b0);
    drain();

    // random phases; the first four pin the registers to their extremes,
    // including sine/cosine patterns beyond unit magnitude
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: program_cfg(avo_ta_pkg::MODE_FLUID, longint'(avo_ta_pkg::Q_MIN), 65536, -65536,
                       longint'(avo_ta_pkg::Q_MAX));
        1: program_cfg(avo_ta_pkg::MODE_DIST, longint'(avo_ta_pkg::Q_MAX), -65536, 65536,
                       longint'(avo_ta_pkg::Q_MIN));
        2: program_cfg(avo_ta_pkg::MODE_SDIST, longint'(avo_ta_pkg::Q_MIN), 131071, -131072,
                       -65536);
        3: program_cfg(avo_ta_pkg::MODE_CLASS, longint'(avo_ta_pkg::Q_MAX), -131072, 131071,
                       longint'(avo_ta_pkg::Q_MAX));
        default: begin
          program_cfg(avo_ta_pkg::mode_t'(phase % 4), rand_q16(), rand_angle(), rand_angle(),
                      ($urandom_range(0, 3) == 0) ? rand_q16()
                        : longint'($urandom_range(0, 524288)) - 262144);
        end
      endcase
      run_phase(40);
      drain();
    end

    if (fail_count == 0 && beats_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
